// ----- rtl/core/imufd_pkg.sv -----
`default_nettype none

package imufd_pkg;

    localparam int unsigned CNT_W   = 4;
    localparam int unsigned DB_W    = 15;
    localparam int unsigned N_WORDS = 3;

    localparam logic [7:0]       SYNC_BYTE  = 8'h55;
    localparam logic [7:0]       TYPE_ACCEL = 8'h51;
    localparam logic [7:0]       TYPE_RATE  = 8'h52;
    localparam logic [7:0]       TYPE_ANGLE = 8'h53;
    localparam logic [7:0]       TYPE_FIELD = 8'h54;
    localparam logic [CNT_W-1:0] LAST_IDX   = 4'd10;  // count seen with the checksum byte
    localparam logic [DB_W-1:0]  DB_RESET   = 15'd31;

    typedef logic signed [15:0] t_word;
    typedef t_word t_triple [N_WORDS];

    // What the assembler reports about the byte sitting at its input
    typedef struct packed {
        logic                    last;    // byte is the checksum byte of an open frame
        logic                    sum_ok;  // byte matches the running sum
        logic [7:0]              ftype;
        logic [N_WORDS*16-1:0]   words;   // word k in bits [16k+15:16k]
    } t_frame_evt;

    // Zero a word whose magnitude is at or below the deadband
    function automatic t_word apply_deadband(input t_word w, input logic [DB_W-1:0] db);
        logic [16:0] mag;
        mag = w[15] ? (17'd0 - {w[15], w}) : {1'b0, w};
        return (mag <= {2'b00, db}) ? t_word'(0) : w;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/imufd_frame.sv -----
`default_nettype none

module imufd_frame (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_step,
    input  wire logic [7:0]       i_byte,
    output imufd_pkg::t_frame_evt o_evt
);
    import imufd_pkg::*;

    logic [CNT_W-1:0] r_count, n_count;
    logic [7:0]       r_sum, n_sum;
    logic [7:0]       r_store [1:7];

    always_comb begin
        n_count = r_count;
        n_sum   = r_sum;
        if (i_step) begin
            if (r_count == '0 && i_byte != SYNC_BYTE) begin
                n_count = r_count;
            end else if (r_count == LAST_IDX) begin
                n_count = '0;
                n_sum   = '0;
            end else begin
                n_count = r_count + 1'b1;
                n_sum   = r_sum + i_byte;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sum   <= '0;
        end else begin
            r_count <= n_count;
            r_sum   <= n_sum;
        end
    end

    // Only type and word bytes are kept; sync and fourth word feed the sum only
    always_ff @(posedge i_clk) begin
        for (int k = 1; k <= 7; k++) begin
            if (i_step && r_count == CNT_W'(k)) begin
                r_store[k] <= i_byte;
            end
        end
    end

    always_comb begin
        o_evt.last   = (r_count == LAST_IDX);
        o_evt.sum_ok = (r_sum == i_byte);
        o_evt.ftype  = r_store[1];
        for (int k = 0; k < N_WORDS; k++) begin
            o_evt.words[16*k +: 16] = {r_store[3 + 2*k], r_store[2 + 2*k]};
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/imu_frame_deframer.sv -----
// Path: o_out_valid rises once a frame's checksum byte has passed the input
// register, then the output register.
// Throughput: one byte per cycle; the input register stalls only when a
// finished angle frame meets a full output register that is not being taken.
// Reset (synchronous, active low): frame empty, running sum and all stored
// words zero, deadband 31, input and output registers empty.
`default_nettype none

module imu_frame_deframer (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // byte request
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic [7:0]                  i_rx_byte,
    // configuration
    input  wire logic                        i_cfg_we,
    input  wire logic [imufd_pkg::DB_W-1:0]  i_cfg_wdata,
    // result request
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output imufd_pkg::t_word                 o_accel_x,
    output imufd_pkg::t_word                 o_accel_y,
    output imufd_pkg::t_word                 o_accel_z,
    output imufd_pkg::t_word                 o_rate_x,
    output imufd_pkg::t_word                 o_rate_y,
    output imufd_pkg::t_word                 o_rate_z,
    output imufd_pkg::t_word                 o_roll_raw,
    output imufd_pkg::t_word                 o_pitch_raw,
    output imufd_pkg::t_word                 o_yaw_raw,
    output imufd_pkg::t_word                 o_field_x,
    output imufd_pkg::t_word                 o_field_y,
    output imufd_pkg::t_word                 o_field_z
);
    import imufd_pkg::*;

    // Input register: one byte waiting to be processed
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    logic [DB_W-1:0] r_deadband;

    t_triple r_accel, r_rate, r_angle, r_field;
    t_triple n_accel, n_rate, n_angle, n_field;

    // Output register
    logic    r_out_valid;
    t_word   r_out [12];

    t_frame_evt w_evt;
    logic       w_good;   // checksum byte of a frame with a matching sum
    logic       w_emit;   // processing this byte produces a result
    logic       w_adv;    // processing this byte now
    t_triple    w_new;

    imufd_frame u_frame (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_adv),
        .i_byte  (r_in_byte),
        .o_evt   (w_evt)
    );

    always_comb begin
        for (int k = 0; k < N_WORDS; k++) begin
            w_new[k] = t_word'(w_evt.words[16*k +: 16]);
        end
    end

    assign w_good = w_evt.last && w_evt.sum_ok;
    assign w_emit = w_good && (w_evt.ftype == TYPE_ANGLE);
    // Hold the byte only if it would emit into an occupied output register that is not being taken
    assign w_adv  = r_in_valid && (!w_emit || !r_out_valid || i_out_ready);

    assign o_in_ready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadband <= DB_RESET;
        end else if (i_cfg_we) begin
            r_deadband <= i_cfg_wdata;
        end
    end

    // Replace the word set named by the frame type; unknown types drop
    always_comb begin
        n_accel = r_accel;
        n_rate  = r_rate;
        n_angle = r_angle;
        n_field = r_field;
        if (w_adv && w_good) begin
            case (w_evt.ftype)
                TYPE_ACCEL: n_accel = w_new;
                TYPE_RATE:  n_rate  = w_new;
                TYPE_ANGLE: n_angle = w_new;
                TYPE_FIELD: n_field = w_new;
                default:    n_accel = r_accel;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < N_WORDS; k++) begin
                r_accel[k] <= '0;
                r_rate[k]  <= '0;
                r_angle[k] <= '0;
                r_field[k] <= '0;
            end
        end else begin
            r_accel <= n_accel;
            r_rate  <= n_rate;
            r_angle <= n_angle;
            r_field <= n_field;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Capture the result: new angle words, stored words of the other kinds, deadband applied to accel x and y
    always_ff @(posedge i_clk) begin
        if (w_adv && w_emit) begin
            r_out[0] <= apply_deadband(r_accel[0], r_deadband);
            r_out[1] <= apply_deadband(r_accel[1], r_deadband);
            r_out[2] <= r_accel[2];
            for (int k = 0; k < N_WORDS; k++) begin
                r_out[3 + k] <= r_rate[k];
                r_out[6 + k] <= w_new[k];
                r_out[9 + k] <= r_field[k];
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_accel_x   = r_out[0];
    assign o_accel_y   = r_out[1];
    assign o_accel_z   = r_out[2];
    assign o_rate_x    = r_out[3];
    assign o_rate_y    = r_out[4];
    assign o_rate_z    = r_out[5];
    assign o_roll_raw  = r_out[6];
    assign o_pitch_raw = r_out[7];
    assign o_yaw_raw   = r_out[8];
    assign o_field_x   = r_out[9];
    assign o_field_y   = r_out[10];
    assign o_field_z   = r_out[11];

    // A finished angle frame always lands in the output register
    a_emit_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && w_emit |=> o_out_valid)
        else $error("emitted result did not reach output register");

    // Never overwrite a result that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready |-> !(w_adv && w_emit))
        else $error("waiting result overwritten");

    // A held byte blocks new requests
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_adv |-> !o_in_ready)
        else $error("input register overwritten while held");

endmodule

`default_nettype wire

// ----- sim/imu_frame_deframer_tb.sv -----
`timescale 1ns / 1ps

module imu_frame_deframer_tb;
    import imufd_pkg::*;

    localparam int unsigned CLK_HALF     = 10;
    localparam int unsigned RESET_CYCLES = 9;
    localparam int unsigned DRAIN_CYCLES = 8;     // well past the deframer's latency
    localparam int unsigned QUIET_LIMIT  = 2000;  // cycles with no request moving
    localparam int unsigned BYTE_TARGET  = 1050;
    localparam int unsigned PHASE_FRAMES = 16;

    // One reading of all twelve words; word 0 is accel_x, word 11 is field_z
    typedef logic [11:0][15:0] t_reading;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic [7:0]          i_rx_byte   = 8'h00;
    logic                i_cfg_we    = 1'b0;
    logic [DB_W-1:0]     i_cfg_wdata = DB_RESET;
    logic                i_out_ready = 1'b0;
    logic                o_in_ready;
    logic                o_out_valid;
    t_word               o_accel_x, o_accel_y, o_accel_z;
    t_word               o_rate_x, o_rate_y, o_rate_z;
    t_word               o_roll_raw, o_pitch_raw, o_yaw_raw;
    t_word               o_field_x, o_field_y, o_field_z;

    imu_frame_deframer u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_rx_byte   (i_rx_byte),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_accel_x   (o_accel_x),
        .o_accel_y   (o_accel_y),
        .o_accel_z   (o_accel_z),
        .o_rate_x    (o_rate_x),
        .o_rate_y    (o_rate_y),
        .o_rate_z    (o_rate_z),
        .o_roll_raw  (o_roll_raw),
        .o_pitch_raw (o_pitch_raw),
        .o_yaw_raw   (o_yaw_raw),
        .o_field_x   (o_field_x),
        .o_field_y   (o_field_y),
        .o_field_z   (o_field_z)
    );

    // ------------------------------------------------------------------
    // Shared bookkeeping
    // ------------------------------------------------------------------
    logic [7:0]      pending_bytes [$];   // bytes waiting for the driver
    t_reading        readings_due  [$];   // predicted readings, oldest first
    logic [DB_W-1:0] deadband_now = DB_RESET;
    int unsigned     in_idle_pct  = 30;
    int unsigned     out_idle_pct = 30;
    int unsigned     mismatches    = 0;
    int unsigned     bytes_taken   = 0;
    int unsigned     bytes_queued  = 0;
    int unsigned     frames_built  = 0;
    int unsigned     readings_seen = 0;
    int unsigned     settings_used = 0;
    int unsigned     quiet_cycles  = 0;

    // Predictor state: the open frame and the last good words of each kind
    logic [7:0]       frm_store [10];
    logic [CNT_W-1:0] frm_count = '0;
    logic [7:0]       frm_sum   = '0;
    t_word            acc_w [3];
    t_word            rate_w [3];
    t_word            ang_w [3];
    t_word            fld_w [3];

    t_reading out_reading;
    t_reading due_reading;
    string    word_names [12] = '{"accel_x", "accel_y", "accel_z", "rate_x", "rate_y",
                                  "rate_z", "roll_raw", "pitch_raw", "yaw_raw",
                                  "field_x", "field_y", "field_z"};

    assign out_reading = {o_field_z, o_field_y, o_field_x, o_yaw_raw, o_pitch_raw,
                          o_roll_raw, o_rate_z, o_rate_y, o_rate_x,
                          o_accel_z, o_accel_y, o_accel_x};

    initial begin
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Zero an acceleration word whose magnitude is within the deadband;
    // the most negative word has magnitude 32768 and always passes.
    function automatic t_word clip_accel(input t_word w, input logic [DB_W-1:0] db);
        int v;
        int mag;
        v   = w;
        mag = (v < 0) ? -v : v;
        return (mag <= int'(db)) ? t_word'(0) : w;
    endfunction

    function automatic t_word stored_word(input int k);
        return t_word'({frm_store[3 + 2 * k], frm_store[2 + 2 * k]});
    endfunction

    // Advance the frame by one accepted byte and queue a reading if a good
    // angle frame closes.
    function automatic void take_byte(input logic [7:0] b);
        t_reading r;
        logic     sum_ok;
        if (frm_count == '0 && b != SYNC_BYTE) begin
            // drop: no frame open and this is not the sync byte
        end else if (frm_count < LAST_IDX) begin
            frm_store[frm_count] = b;
            frm_sum   = frm_sum + b;
            frm_count = frm_count + 1'b1;
        end else begin
            // checksum byte: judge, then clear the frame whatever the outcome
            sum_ok    = (frm_sum == b);
            frm_count = '0;
            frm_sum   = '0;
            if (sum_ok) begin
                case (frm_store[1])
                    TYPE_ACCEL: for (int k = 0; k < 3; k++) acc_w[k]  = stored_word(k);
                    TYPE_RATE:  for (int k = 0; k < 3; k++) rate_w[k] = stored_word(k);
                    TYPE_FIELD: for (int k = 0; k < 3; k++) fld_w[k]  = stored_word(k);
                    TYPE_ANGLE: begin
                        for (int k = 0; k < 3; k++) ang_w[k] = stored_word(k);
                        r[0] = clip_accel(acc_w[0], deadband_now);
                        r[1] = clip_accel(acc_w[1], deadband_now);
                        r[2] = acc_w[2];
                        for (int k = 0; k < 3; k++) begin
                            r[3 + k] = rate_w[k];
                            r[6 + k] = ang_w[k];
                            r[9 + k] = fld_w[k];
                        end
                        readings_due = {readings_due, r};
                    end
                    default: begin
                        // unknown type: drop the frame
                    end
                endcase
            end
        end
    endfunction

    // Run the predictor on every accepted byte request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            frm_count = '0;
            frm_sum   = '0;
            for (int k = 0; k < 3; k++) begin
                acc_w[k]  = '0;
                rate_w[k] = '0;
                ang_w[k]  = '0;
                fld_w[k]  = '0;
            end
        end else if (i_in_valid && o_in_ready) begin
            bytes_taken++;
            take_byte(i_rx_byte);
        end
    end

    // ------------------------------------------------------------------
    // Driver: hold each byte request until it is taken, idle at random
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready) begin
            if (pending_bytes.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
                i_in_valid <= 1'b1;
                i_rx_byte  <= pending_bytes.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: stall the result side at random, check each taken reading
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input int got, input int want);
        $display("deframer error at %0t: %s got %0d, expected %0d", $realtime, what, got,
                 want);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= out_idle_pct);
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (readings_due.size() == 0) begin
                report_mismatch("reading with none due, accel_x",
                                int'($signed(out_reading[0])), 0);
            end else begin
                due_reading = readings_due.pop_front();
                for (int k = 0; k < 12; k++) begin
                    if (out_reading[k] !== due_reading[k]) begin
                        report_mismatch(word_names[k], int'($signed(out_reading[k])),
                                        int'($signed(due_reading[k])));
                    end
                end
            end
            readings_seen++;
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run if no request moves for too long
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("deframer timeout: no request moved for %0d cycles", QUIET_LIMIT);
        $display("imu_frame_deframer: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Append one byte to the driver's queue
    function automatic void queue_byte(input logic [7:0] b);
        pending_bytes = {pending_bytes, b};
        bytes_queued++;
    endfunction

    // Any byte except the sync byte, so it never opens a frame on its own
    function automatic logic [7:0] filler_byte();
        logic [7:0] b;
        b = 8'($urandom);
        return (b == SYNC_BYTE) ? 8'h00 : b;
    endfunction

    function automatic logic [15:0] pick_word();
        case ($urandom_range(7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'hFFFF;
            3:       return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    // Acceleration words cluster around the deadband edges
    function automatic logic [15:0] pick_accel(input logic [DB_W-1:0] db);
        logic [15:0] edge_w;
        edge_w = {1'b0, db};
        case ($urandom_range(9))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return edge_w;
            3:       return -edge_w;
            4:       return edge_w + 16'd1;
            5:       return -(edge_w + 16'd1);
            6:       return 16'($urandom_range(int'(db)));
            default: return 16'($urandom);
        endcase
    endfunction

    // Queue one frame; the fourth word only feeds the checksum
    task automatic push_frame(input logic [7:0] ftype, input logic [15:0] w0,
                              input logic [15:0] w1, input logic [15:0] w2,
                              input logic [15:0] w3, input bit bad_sum);
        logic [7:0] fb [10];
        logic [7:0] sum;
        fb = '{SYNC_BYTE, ftype, w0[7:0], w0[15:8], w1[7:0], w1[15:8],
               w2[7:0], w2[15:8], w3[7:0], w3[15:8]};
        sum = '0;
        for (int k = 0; k < 10; k++) begin
            queue_byte(fb[k]);
            sum = sum + fb[k];
        end
        if (bad_sum) sum = sum ^ 8'($urandom_range(255, 1));
        queue_byte(sum);
        frames_built++;
    endtask

    // Mostly well-formed frames with random content, plus noise, bad sums,
    // unknown types and cut-off frames.
    task automatic random_phase(input int n_frames);
        int          pick;
        int          cut;
        logic [7:0]  ftype;
        for (int f = 0; f < n_frames; f++) begin
            if ($urandom_range(99) < 10) begin
                repeat ($urandom_range(3, 1)) queue_byte(filler_byte());
            end
            pick = $urandom_range(99);
            if (pick < 4) begin
                // cut-off frame; flush with enough filler to close it
                cut = $urandom_range(9);
                queue_byte(SYNC_BYTE);
                repeat (cut) queue_byte(8'($urandom));
                repeat (11) queue_byte(filler_byte());
            end else if (pick < 34) begin
                push_frame(TYPE_ANGLE, pick_word(), pick_word(), pick_word(), pick_word(), 0);
            end else if (pick < 52) begin
                push_frame(TYPE_ACCEL, pick_accel(deadband_now), pick_accel(deadband_now),
                           pick_accel(deadband_now), pick_word(), 0);
            end else if (pick < 66) begin
                push_frame(TYPE_RATE, pick_word(), pick_word(), pick_word(), pick_word(), 0);
            end else if (pick < 80) begin
                push_frame(TYPE_FIELD, pick_word(), pick_word(), pick_word(), pick_word(), 0);
            end else if (pick < 88) begin
                ftype = 8'($urandom);
                while (ftype >= TYPE_ACCEL && ftype <= TYPE_FIELD) ftype = 8'($urandom);
                push_frame(ftype, pick_word(), pick_word(), pick_word(), pick_word(), 0);
            end else begin
                // known type, wrong checksum
                ftype = TYPE_ACCEL + 8'($urandom_range(3));
                push_frame(ftype, pick_accel(deadband_now), pick_word(), pick_word(),
                           pick_word(), 1);
            end
        end
    endtask

    // Hold until every byte is taken and every reading is back, then let
    // the pipeline settle; sample on the falling edge where all is stable
    task automatic wait_idle();
        while (pending_bytes.size() != 0 || i_in_valid || readings_due.size() != 0 ||
               o_out_valid) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_deadband(input logic [DB_W-1:0] db);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= db;
        @(posedge i_clk);
        i_cfg_we     <= 1'b0;
        deadband_now  = db;
        settings_used++;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int              phase;
        logic [DB_W-1:0] db;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: stray bytes outside a frame, an acceleration frame at the
        // word extremes (most negative passes the deadband), then an angle
        // frame to publish it, under the reset deadband.
        queue_byte(8'h00);
        queue_byte(8'hFF);
        push_frame(TYPE_ACCEL, 16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 0);
        push_frame(TYPE_ANGLE, 16'h7FFF, 16'h8000, 16'h0001, 16'h0000, 0);

        // Random phases, each under its own deadband; the fourth phase runs
        // with no idling on either side.
        phase = 0;
        while (bytes_queued < BYTE_TARGET) begin
            case (phase)
                0:       db = '0;
                1:       db = '1;
                2:       db = DB_RESET;
                default: db = $urandom_range(1) ? DB_W'($urandom_range(400))
                                                : DB_W'($urandom);
            endcase
            wait_idle();
            in_idle_pct  = (phase == 3) ? 0 : 30;
            out_idle_pct = (phase == 3) ? 0 : 30;
            set_deadband(db);
            @(negedge i_clk);
            random_phase(PHASE_FRAMES);
            phase++;
        end
        wait_idle();

        if (readings_due.size() != 0) begin
            report_mismatch("readings never delivered", 0, readings_due.size());
        end

        $display("deframer run: %0d bytes taken, %0d frames built, %0d readings checked",
                 bytes_taken, frames_built, readings_seen);
        $display("deframer run: %0d deadband settings beyond reset, %0d errors",
                 settings_used, mismatches);
        if (mismatches == 0) begin
            $display("imu_frame_deframer: match");
        end else begin
            $display("imu_frame_deframer: mismatch");
        end
        $finish;
    end

endmodule

// ----- imu_frame_deframer.f -----
rtl/core/imufd_pkg.sv
rtl/core/imufd_frame.sv
rtl/core/imu_frame_deframer.sv
sim/imu_frame_deframer_tb.sv
